/* rtl/hsp_pkg.sv */
// Shared types and codes for the hard-sphere placer.
// No dependencies; imported by the distance unit and the top level.
package hsp_pkg;

	// width of the configuration register index
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SPACE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACE_Z = 2'd2;

	// result status codes
	localparam logic [2:0] ST_PLACED  = 3'd0;
	localparam logic [2:0] ST_OVERLAP = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_NOFIT   = 3'd3;
	localparam logic [2:0] ST_CLEARED = 3'd4;

	// status from the overlap pipeline back to the sequencer
	typedef struct packed {
		logic valid;  // a compare result leaves the last stage
		logic hit;    // that compare found an overlap
		logic busy;   // some compare is still in flight
	} dist_res_t;

endpackage

/* rtl/hard_sphere_random_placer.sv */
// Top level of the hard-sphere random sequential placer.
// Depends on hsp_pkg and hsp_dist.
//
// One request either clears the placed set (mode 1) or tries to place one
// sphere (mode 0). A placement attempt works out the candidate centre on each
// axis, radius + ((space - 2*radius) * frac >> FRACTION_BITS), with one shared
// multiplier over three axes, then streams every placed sphere out of the
// sphere store, one entry a cycle, through a five-deep overlap pipeline
// (registered read plus four compute stages). The scan covers every sphere
// placed so far. Clear, radius does not fit and store full requests go from
// the check straight to the result, with no multiply and no scan. Only one
// request is worked on at a time: in_stall is high from acceptance until the
// result is loaded into the output register, which may still wait on out_stall
// while the next request is taken. A clean candidate is written to the store
// at index count_q, the number placed so far, and reported with that slot; a
// rejected one is reported with its centre so software can retry with new
// fractions. space_x/y/z must be written through the cfg port only while the
// block is idle; the block itself does not enforce this.
module hard_sphere_random_placer #(
	parameter int MAX_SPHERES   = 256,
	parameter int LENGTH_BITS   = 20,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [hsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [LENGTH_BITS-1:0]        cfg_data,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [LENGTH_BITS-1:0]        radius,
	input  logic [FRACTION_BITS-1:0]      frac_x,
	input  logic [FRACTION_BITS-1:0]      frac_y,
	input  logic [FRACTION_BITS-1:0]      frac_z,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    status,
	output logic [LENGTH_BITS-1:0]        centre_x,
	output logic [LENGTH_BITS-1:0]        centre_y,
	output logic [LENGTH_BITS-1:0]        centre_z,
	output logic [7:0]                    slot
);
	import hsp_pkg::*;

	localparam int LB    = LENGTH_BITS;
	localparam int FB    = FRACTION_BITS;
	localparam int IDX_W = $clog2(MAX_SPHERES);
	localparam int CNT_W = $clog2(MAX_SPHERES + 1);
	localparam int ENT_W = 4 * LB;
	localparam int PRD_W = LB + FB;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SPHERES);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CHK   = 7'b0000010,
		S_MUL   = 7'b0000100,
		S_ADD   = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_DRAIN = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	// config registers
	logic [LB-1:0] space_x_q, space_y_q, space_z_q;

	// request registers
	logic          mode_q;
	logic [LB-1:0] r_q;
	logic [FB-1:0] fx_q, fy_q, fz_q;

	// sequencer
	logic [1:0]       axis_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic [2:0]       res_st_q;
	logic             hit_q;

	// centre arithmetic
	logic [LB-1:0]    cen_q [3];
	logic [PRD_W-1:0] prod_q;
	logic [LB-1:0]    space_sel;
	logic [FB-1:0]    frac_sel;
	logic [LB:0]      dbl_r;
	logic [LB:0]      range_full;
	logic             no_fit;

	// sphere store: {x, y, z, radius} per entry
	logic [ENT_W-1:0] mem_q [MAX_SPHERES];
	logic [ENT_W-1:0] rd_data_q;
	logic             rd_vld_q;
	logic             rd_en;

	// output register
	logic             out_valid_q;
	logic             out_free;
	logic             in_take;

	dist_res_t        dres;

	assign in_stall  = (state_q != S_IDLE);
	assign in_take   = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = ~out_valid_q | ~out_stall;

	assign dbl_r  = {r_q, 1'b0};
	assign no_fit = (dbl_r > {1'b0, space_x_q}) | (dbl_r > {1'b0, space_y_q}) |
	                (dbl_r > {1'b0, space_z_q});

	always_comb begin
		case (axis_q)
			2'd0: begin
				space_sel = space_x_q;
				frac_sel  = fx_q;
			end
			2'd1: begin
				space_sel = space_y_q;
				frac_sel  = fy_q;
			end
			default: begin
				space_sel = space_z_q;
				frac_sel  = fz_q;
			end
		endcase
	end

	// fit has been checked, so the difference never goes negative
	assign range_full = {1'b0, space_sel} - dbl_r;

	assign rd_en = (state_q == S_SCAN);

	// config writes; an index beyond the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_x_q <= '1;
			space_y_q <= '1;
			space_z_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SPACE_X: space_x_q <= cfg_data;
				CFG_SPACE_Y: space_y_q <= cfg_data;
				CFG_SPACE_Z: space_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_q <= mode;
			r_q    <= radius;
			fx_q   <= frac_x;
			fy_q   <= frac_y;
			fz_q   <= frac_z;
		end
	end

	// shared multiplier and centre adder
	always_ff @(posedge clk) begin
		if (state_q == S_MUL)
			prod_q <= PRD_W'(range_full[LB-1:0]) * PRD_W'(frac_sel);
		if (state_q == S_ADD)
			cen_q[axis_q] <= r_q + prod_q[PRD_W-1:FB];
	end

	// sphere store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free && res_st_q == ST_PLACED)
			mem_q[count_q[IDX_W-1:0]] <= {cen_q[0], cen_q[1], cen_q[2], r_q};
		if (rd_en)
			rd_data_q <= mem_q[scan_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_vld_q <= 1'b0;
		else
			rd_vld_q <= rd_en;
	end

	hsp_dist #(
		.LENGTH_BITS(LB)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.ent_vld(rd_vld_q),
		.cand_x (cen_q[0]),
		.cand_y (cen_q[1]),
		.cand_z (cen_q[2]),
		.cand_r (r_q),
		.ent_x  (rd_data_q[4*LB-1:3*LB]),
		.ent_y  (rd_data_q[3*LB-1:2*LB]),
		.ent_z  (rd_data_q[2*LB-1:LB]),
		.ent_r  (rd_data_q[LB-1:0]),
		.res    (dres)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			axis_q   <= 2'd0;
			count_q  <= '0;
			scan_q   <= '0;
			res_st_q <= ST_PLACED;
			hit_q    <= 1'b0;
		end else begin
			if (dres.hit)
				hit_q <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (in_take)
						state_q <= S_CHK;
				end
				S_CHK: begin
					axis_q <= 2'd0;
					scan_q <= '0;
					hit_q  <= 1'b0;
					if (mode_q) begin
						res_st_q <= ST_CLEARED;
						state_q  <= S_DONE;
					end else if (no_fit) begin
						res_st_q <= ST_NOFIT;
						state_q  <= S_DONE;
					end else if (count_q == CNT_MAX) begin
						res_st_q <= ST_FULL;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (axis_q == 2'd2)
						state_q <= (count_q == '0) ? S_DRAIN : S_SCAN;
					else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q + 1'b1 == count_q)
						state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					// everything in flight has reached hit_q once busy drops
					if (!rd_vld_q && !dres.busy) begin
						res_st_q <= hit_q ? ST_OVERLAP : ST_PLACED;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						if (res_st_q == ST_PLACED)
							count_q <= count_q + 1'b1;
						else if (res_st_q == ST_CLEARED)
							count_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_DONE && out_free)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		logic [31:0] cnt_ext;
		logic        has_cen;
		cnt_ext = 32'(count_q);
		has_cen = (res_st_q == ST_PLACED) || (res_st_q == ST_OVERLAP);
		if (state_q == S_DONE && out_free) begin
			status   <= res_st_q;
			centre_x <= has_cen ? cen_q[0] : '0;
			centre_y <= has_cen ? cen_q[1] : '0;
			centre_z <= has_cen ? cen_q[2] : '0;
			slot     <= (res_st_q == ST_PLACED) ? cnt_ext[7:0] : 8'd0;
		end
	end

endmodule

/* rtl/hsp_dist.sv */
// Pipelined overlap test: one stored sphere per cycle against the candidate.
// Depends on hsp_pkg (dist_res_t).
module hsp_dist #(
	parameter int LENGTH_BITS = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   ent_vld,
	input  logic [LENGTH_BITS-1:0] cand_x,
	input  logic [LENGTH_BITS-1:0] cand_y,
	input  logic [LENGTH_BITS-1:0] cand_z,
	input  logic [LENGTH_BITS-1:0] cand_r,
	input  logic [LENGTH_BITS-1:0] ent_x,
	input  logic [LENGTH_BITS-1:0] ent_y,
	input  logic [LENGTH_BITS-1:0] ent_z,
	input  logic [LENGTH_BITS-1:0] ent_r,
	output hsp_pkg::dist_res_t     res
);
	import hsp_pkg::*;

	localparam int LB    = LENGTH_BITS;
	localparam int SQ_W  = 2 * LB;
	localparam int SUM_W = 2 * LB + 2;

	logic            vld_s1, vld_s2, vld_s3, vld_s4;
	logic [LB-1:0]   dx_s1, dy_s1, dz_s1;
	logic [LB:0]     rs_s1;
	logic [SQ_W-1:0] dx2_s2, dy2_s2, dz2_s2;
	logic [SUM_W-1:0] rs2_s2, rs2_s3, d2_s3;
	logic            hit_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= ent_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// s1: absolute differences and radius sum
	always_ff @(posedge clk) begin
		dx_s1 <= (cand_x > ent_x) ? cand_x - ent_x : ent_x - cand_x;
		dy_s1 <= (cand_y > ent_y) ? cand_y - ent_y : ent_y - cand_y;
		dz_s1 <= (cand_z > ent_z) ? cand_z - ent_z : ent_z - cand_z;
		rs_s1 <= {1'b0, cand_r} + {1'b0, ent_r};
	end

	// s2: squares
	always_ff @(posedge clk) begin
		dx2_s2 <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
		dy2_s2 <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
		dz2_s2 <= SQ_W'(dz_s1) * SQ_W'(dz_s1);
		rs2_s2 <= SUM_W'(rs_s1) * SUM_W'(rs_s1);
	end

	// s3: squared distance
	always_ff @(posedge clk) begin
		d2_s3  <= SUM_W'(dx2_s2) + SUM_W'(dy2_s2) + SUM_W'(dz2_s2);
		rs2_s3 <= rs2_s2;
	end

	// s4: strict compare, touching is not an overlap
	always_ff @(posedge clk) begin
		hit_s4 <= d2_s3 < rs2_s3;
	end

	assign res.valid = vld_s4;
	assign res.hit   = vld_s4 & hit_s4;
	assign res.busy  = vld_s1 | vld_s2 | vld_s3 | vld_s4;

endmodule

/* dv/tb_hard_sphere_random_placer.sv */
// Self-checking testbench for hard_sphere_random_placer: directed corner cases,
// then phases of random placement requests under varied idling and box sizes.
// Depends on hsp_pkg and the RTL of the placer; a scoreboard class predicts results.
module tb_hard_sphere_random_placer;
	import hsp_pkg::*;

	localparam int LEN_W  = 20;
	localparam int FRAC_W = 16;
	localparam int STORE_DEPTH = 256;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	// one request as the block sees it
	typedef struct packed {
		logic              mode;
		logic [LEN_W-1:0]  radius;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
		logic [FRAC_W-1:0] fz;
	} sphere_req_t;

	// one result as the block reports it
	typedef struct packed {
		logic [2:0]       status;
		logic [LEN_W-1:0] cx;
		logic [LEN_W-1:0] cy;
		logic [LEN_W-1:0] cz;
		logic [7:0]       slot;
	} placement_t;

	// Mirror of the placer: box registers, the sphere store and its fill count.
	// Each accepted request is turned into the placement the block must report.
	class placement_scoreboard;
		logic [LEN_W-1:0] box_x, box_y, box_z;
		logic [LEN_W-1:0] pos_x [0:STORE_DEPTH-1];
		logic [LEN_W-1:0] pos_y [0:STORE_DEPTH-1];
		logic [LEN_W-1:0] pos_z [0:STORE_DEPTH-1];
		logic [LEN_W-1:0] rad   [0:STORE_DEPTH-1];
		int unsigned n_placed;
		placement_t pending_placements[$];
		int errors;
		int status_seen [0:7];

		function new();
			box_x = LEN_MAX;
			box_y = LEN_MAX;
			box_z = LEN_MAX;
			n_placed = 0;
			errors = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void set_box(logic [LEN_W-1:0] x, logic [LEN_W-1:0] y, logic [LEN_W-1:0] z);
			box_x = x;
			box_y = y;
			box_z = z;
		endfunction

		function int pending();
			return pending_placements.size();
		endfunction

		// r + floor((side - 2r) * f / 2^16); caller guarantees 2r <= side
		function logic [LEN_W-1:0] axis_centre(logic [LEN_W-1:0] r, logic [LEN_W-1:0] side,
			logic [FRAC_W-1:0] f);
			longint unsigned span;
			span = longint'(side) - 2 * longint'(r);
			return LEN_W'(longint'(r) + ((span * longint'(f)) >> FRAC_W));
		endfunction

		// exact squared-distance test against every stored sphere
		function bit hits_stored(logic [LEN_W-1:0] cx, logic [LEN_W-1:0] cy,
			logic [LEN_W-1:0] cz, logic [LEN_W-1:0] r);
			longint unsigned dx, dy, dz, rs;
			for (int i = 0; i < n_placed; i++) begin
				dx = (cx > pos_x[i]) ? longint'(cx) - pos_x[i] : longint'(pos_x[i]) - cx;
				dy = (cy > pos_y[i]) ? longint'(cy) - pos_y[i] : longint'(pos_y[i]) - cy;
				dz = (cz > pos_z[i]) ? longint'(cz) - pos_z[i] : longint'(pos_z[i]) - cz;
				rs = longint'(r) + rad[i];
				if (dx * dx + dy * dy + dz * dz < rs * rs) return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_request(sphere_req_t req);
			placement_t p;
			longint unsigned twice_r;
			p = '0;
			twice_r = 2 * longint'(req.radius);
			if (req.mode) begin
				n_placed = 0;
				p.status = ST_CLEARED;
			end else if (twice_r > box_x || twice_r > box_y || twice_r > box_z) begin
				p.status = ST_NOFIT;
			end else if (n_placed >= STORE_DEPTH) begin
				p.status = ST_FULL;
			end else begin
				p.cx = axis_centre(req.radius, box_x, req.fx);
				p.cy = axis_centre(req.radius, box_y, req.fy);
				p.cz = axis_centre(req.radius, box_z, req.fz);
				if (hits_stored(p.cx, p.cy, p.cz, req.radius)) begin
					p.status = ST_OVERLAP;
				end else begin
					p.status = ST_PLACED;
					p.slot = n_placed[7:0];
					pos_x[n_placed] = p.cx;
					pos_y[n_placed] = p.cy;
					pos_z[n_placed] = p.cz;
					rad[n_placed] = req.radius;
					n_placed++;
				end
			end
			pending_placements.push_back(p);
		endfunction

		function void match_field(string name, longint unsigned want, longint unsigned seen);
			if (want != seen) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
			end
		endfunction

		function void check_placement(placement_t got);
			placement_t want;
			if (pending_placements.size() == 0) begin
				errors++;
				$display("%0t: result with no request outstanding, status %0d", $time, got.status);
				return;
			end
			want = pending_placements.pop_front();
			status_seen[want.status]++;
			match_field("status", want.status, got.status);
			match_field("centre_x", want.cx, got.cx);
			match_field("centre_y", want.cy, got.cy);
			match_field("centre_z", want.cz, got.cz);
			match_field("slot", want.slot, got.slot);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LEN_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 mode;
	logic [LEN_W-1:0]     radius;
	logic [FRAC_W-1:0]    frac_x;
	logic [FRAC_W-1:0]    frac_y;
	logic [FRAC_W-1:0]    frac_z;
	logic                 out_valid;
	logic                 out_stall;
	logic [2:0]           status;
	logic [LEN_W-1:0]     centre_x;
	logic [LEN_W-1:0]     centre_y;
	logic [LEN_W-1:0]     centre_z;
	logic [7:0]           slot;

	placement_scoreboard sb;

	// idling knobs, percent per cycle; hold_left forces a long result stall
	int gap_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;

	hard_sphere_random_placer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.radius    (radius),
		.frac_x    (frac_x),
		.frac_y    (frac_y),
		.frac_z    (frac_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.centre_x  (centre_x),
		.centre_y  (centre_y),
		.centre_z  (centre_z),
		.slot      (slot)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: far beyond the slowest legal run (every attempt against a full
	// store, plus stalls and the long hold-off).
	initial begin
		#20_000_000;
		$display("[hard_sphere_random_placer] ERROR");
		$finish;
	end

	// Result side. Outputs are sampled right after the edge, so they hold the
	// values the block presented at that edge; out_stall is what it saw too.
	// A pending long hold-off is counted down here, one cycle at a time.
	initial begin
		placement_t got;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got.status = status;
				got.cx = centre_x;
				got.cy = centre_y;
				got.cz = centre_z;
				got.slot = slot;
				sb.check_placement(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic sphere_req_t req_of(logic m, logic [LEN_W-1:0] r, logic [FRAC_W-1:0] fx,
		logic [FRAC_W-1:0] fy, logic [FRAC_W-1:0] fz);
		sphere_req_t q;
		q.mode = m;
		q.radius = r;
		q.fx = fx;
		q.fy = fy;
		q.fz = fz;
		return q;
	endfunction

	// Random fraction, now and then pinned at an end of its range.
	function automatic logic [FRAC_W-1:0] pick_frac();
		if ($urandom_range(9) == 0) return $urandom_range(1) ? '1 : '0;
		return FRAC_W'($urandom);
	endfunction

	// Mostly well-formed attempts sized against the box; some clears, some
	// radii right at the fit boundary and some raw noise.
	function automatic sphere_req_t gen_request(logic [LEN_W-1:0] side_min);
		sphere_req_t q;
		int roll;
		roll = $urandom_range(99);
		q.mode = (roll < 4);
		if (roll < 10)
			q.radius = LEN_W'($urandom);
		else if (roll < 18)
			q.radius = LEN_W'((side_min >> 1) + $urandom_range(2) - 1);
		else
			q.radius = LEN_W'($urandom_range(side_min >> 3));
		q.fx = pick_frac();
		q.fy = pick_frac();
		q.fz = pick_frac();
		return q;
	endfunction

	// Offer one request and hold it until accepted. Valid is only lowered
	// inside an idle gap, so back-to-back requests keep it high.
	task automatic send_request(sphere_req_t q);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= q.mode;
		radius <= q.radius;
		frac_x <= q.fx;
		frac_y <= q.fy;
		frac_z <= q.fz;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(q);
	endtask

	// Sender stops and waits for every outstanding result.
	task automatic wait_drain();
		if (in_valid) in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Box registers are written only with the block idle; a short settle
	// first, then the three writes on consecutive edges.
	task automatic write_box(logic [LEN_W-1:0] x, logic [LEN_W-1:0] y, logic [LEN_W-1:0] z);
		repeat (16) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SPACE_X;
		cfg_data <= x;
		@(posedge clk);
		cfg_index <= CFG_SPACE_Y;
		cfg_data <= y;
		@(posedge clk);
		cfg_index <= CFG_SPACE_Z;
		cfg_data <= z;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_box(x, y, z);
	endtask

	task automatic set_idling(int kind);
		case (kind)
			0: begin
				gap_pct = 0;
				stall_pct = 0;
			end
			1: begin
				gap_pct = 46;
				stall_pct = 0;
			end
			2: begin
				gap_pct = 0;
				stall_pct = 46;
			end
			default: begin
				gap_pct = 15;
				stall_pct = 15;
			end
		endcase
	endtask

	initial begin
		logic [LEN_W-1:0] bx, by, bz, side_min;
		int n_sent;
		n_sent = 0;
		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SPACE_X;
		cfg_data <= '0;
		in_valid <= 1'b0;
		mode <= 1'b0;
		radius <= '0;
		frac_x <= '0;
		frac_y <= '0;
		frac_z <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset box (all ones): zero-radius spheres at one point do not
		// collide, the largest radius that fits, the first that does not.
		send_request(req_of(1'b0, '0, '0, '0, '0));
		send_request(req_of(1'b0, '0, '0, '0, '0));
		send_request(req_of(1'b0, '0, '1, '1, '1));
		send_request(req_of(1'b0, 20'h7ffff, '1, '1, '1));
		send_request(req_of(1'b0, 20'h80000, '1, '0, '1));
		send_request(req_of(1'b0, '1, '1, '1, '1));
		send_request(req_of(1'b1, '1, '1, '1, '1));

		// Box of 2*100 + 2^16: centre = 100 + frac exactly, so spheres can be
		// set to touch (allowed) or miss touching by one (overlap).
		wait_drain();
		write_box(20'd65736, 20'd65736, 20'd65736);
		send_request(req_of(1'b0, 20'd100, 16'd0, 16'd0, 16'd0));
		send_request(req_of(1'b0, 20'd100, 16'd200, 16'd0, 16'd0));
		send_request(req_of(1'b0, 20'd100, 16'd199, 16'd0, 16'd0));
		send_request(req_of(1'b0, 20'd100, 16'd0, 16'd200, 16'd0));
		send_request(req_of(1'b0, 20'd100, 16'd0, 16'd0, 16'd199));
		// radius exactly half the box: centre is the radius
		send_request(req_of(1'b0, 20'd32868, '1, '1, '1));
		send_request(req_of(1'b1, '0, '0, '0, '0));

		// Fit fails on one axis only.
		wait_drain();
		write_box(LEN_MAX, LEN_MAX, 20'd10);
		send_request(req_of(1'b0, 20'd6, 16'h8000, 16'h8000, 16'h8000));
		send_request(req_of(1'b0, 20'd5, '1, '1, '1));
		send_request(req_of(1'b1, '0, '0, '0, '0));

		// Empty box: only a zero radius fits.
		wait_drain();
		write_box('0, '0, '0);
		send_request(req_of(1'b0, '0, '1, '1, '1));
		send_request(req_of(1'b0, 20'd1, '0, '0, '0));
		send_request(req_of(1'b1, '0, '0, '0, '0));

		for (int p = 0; p < 9; p++) begin
			wait_drain();
			case (p)
				0, 6: begin
					bx = LEN_MAX;
					by = LEN_MAX;
					bz = LEN_MAX;
				end
				1: begin
					bx = LEN_W'($urandom_range(400, 64));
					by = LEN_W'($urandom_range(400, 64));
					bz = LEN_W'($urandom_range(400, 64));
				end
				2: begin
					bx = LEN_W'($urandom_range(5000, 1000));
					by = LEN_W'($urandom_range(5000, 1000));
					bz = LEN_W'($urandom_range(5000, 1000));
				end
				3: begin
					bx = LEN_MAX;
					by = LEN_W'($urandom_range(300, 40));
					bz = LEN_W'($urandom);
				end
				5: begin
					bx = LEN_W'($urandom_range(80, 20));
					by = LEN_W'($urandom_range(80, 20));
					bz = LEN_W'($urandom_range(80, 20));
				end
				default: begin
					bx = LEN_W'($urandom);
					by = LEN_W'($urandom);
					bz = LEN_W'($urandom);
				end
			endcase
			write_box(bx, by, bz);
			set_idling(p % 4);
			side_min = bx;
			if (by < side_min) side_min = by;
			if (bz < side_min) side_min = bz;

			if (p == 0) begin
				// Tiny spheres in the widest box: fills all slots, then the
				// store reports full; a too-large radius still wins over full.
				for (int k = 0; k < 270; k++)
					send_request(req_of(1'b0, LEN_W'($urandom_range(1)), pick_frac(),
						pick_frac(), pick_frac()));
				for (int k = 0; k < 3; k++)
					send_request(req_of(1'b0, 20'h80000, pick_frac(), pick_frac(), pick_frac()));
				send_request(req_of(1'b1, LEN_W'($urandom), pick_frac(), pick_frac(),
					pick_frac()));
				n_sent += 274;
			end else begin
				// long result hold-off while requests keep coming: the output
				// register fills and the block must stall its input
				if (p == 2) hold_left = 1500;
				for (int k = 0; k < 28; k++) begin
					if (p == 3 && k == 14) wait_drain();
					send_request(gen_request(side_min));
				end
				n_sent += 28;
			end
		end

		wait_drain();
		repeat (300) @(posedge clk);
		$display("%0d random and 20 directed requests: %0d placed, %0d overlaps, %0d full,",
			n_sent, sb.status_seen[ST_PLACED], sb.status_seen[ST_OVERLAP],
			sb.status_seen[ST_FULL]);
		$display("%0d no-fit, %0d clears, %0d mismatches", sb.status_seen[ST_NOFIT],
			sb.status_seen[ST_CLEARED], sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[hard_sphere_random_placer] OK");
		end else begin
			$display("[hard_sphere_random_placer] ERROR");
		end
		$finish;
	end

endmodule
